/* src/ptts_pkg.sv */
// Shared types, constants and helpers for the periodic task tick scheduler.
package ptts_pkg;

	// Task table geometry.
	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);

	// Field widths.
	localparam int WORK_W     = 16;
	localparam int TIME_W     = 32;
	localparam int CHOSEN_W   = 4;
	localparam int ACT_W      = 2;
	localparam int NUM_W      = 5;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 40;

	// Item kinds carried on the input tuser.
	localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_POLICY    = 1'b0;
	localparam logic CFG_NUM_TASKS = 1'b1;

	// Scheduling policies.
	localparam logic POL_RM  = 1'b0;
	localparam logic POL_EDF = 1'b1;

	// One task table entry as seen by the shared step unit.
	typedef struct packed {
		logic [WORK_W-1:0] job;
		logic [WORK_W-1:0] period;
		logic [WORK_W-1:0] rel;
		logic [WORK_W-1:0] rem;
		logic [TIME_W-1:0] next_rel;
		logic [TIME_W-1:0] dl;
	} entry_t;

	// Result of one step of the shared unit.
	typedef struct packed {
		entry_t            upd;
		logic [TIME_W-1:0] key;
		logic              take;
	} step_t;

	// Add a 16-bit offset to a time value, saturating at the top.
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [WORK_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {{(TIME_W - WORK_W + 1){1'b0}}, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

/* src/ptts_alu.sv */
// Shared step unit: releases one entry if due, then ranks it against the best so far.
module ptts_alu (
	input  logic                         policy,
	input  logic [ptts_pkg::TIME_W-1:0]  now,
	input  ptts_pkg::entry_t             cur,
	input  logic                         found,
	input  logic [ptts_pkg::TIME_W-1:0]  best_key,
	output ptts_pkg::step_t              res
);

	ptts_pkg::entry_t upd;
	logic [ptts_pkg::TIME_W-1:0] key;

	// Release a new job when the entry's release time has come.
	always_comb begin
		upd = cur;
		if (cur.next_rel == now) begin
			upd.rem = cur.job;
			if (policy == ptts_pkg::POL_EDF) begin
				upd.dl = ptts_pkg::sat_add(now, cur.rel);
			end
			upd.next_rel = ptts_pkg::sat_add(cur.next_rel, cur.period);
		end
	end

	// Priority key: shorter period or earlier deadline wins; ties keep the earlier entry.
	always_comb begin
		if (policy == ptts_pkg::POL_EDF) begin
			key = upd.dl;
		end else begin
			key = ptts_pkg::TIME_W'(upd.period);
		end
		res.upd  = upd;
		res.key  = key;
		res.take = (upd.rem != '0) && (!found || (key < best_key));
	end

endmodule

/* src/periodic_task_tick_scheduler.sv */
// Periodic task tick scheduler.
// Input items arrive on the s_axis channel; tuser selects the kind of item:
// a tick advances time by one unit, a load writes one task table entry, and a
// restart rewinds time and clears all pending work. Every item returns exactly
// one result item on the m_axis channel: the task that ran in the tick, or an
// idle result for idle ticks and for loads and restarts.
// The user must write policy and the number of active tasks on the cfg channel only
// while the block is idle; the block itself does not enforce this. cfg_ready is always high.
// A tick walks the active entries through one shared step unit, one entry per
// cycle, then passes through the decrement and done states, where it waits for
// the output register, before the next item is accepted. A load goes straight to
// the done state, and a restart first sweeps the whole table in the clear state.
// The block takes one item at a time; s_axis_tready is high only between items.
// Results sit in an output register, so a new item is accepted while a result
// waits; if the receiver stalls, the next result holds inside until the output
// register frees up. Reset clears time, pending work, release times, deadlines
// and the configuration registers; task parameters are undefined until loaded.
module periodic_task_tick_scheduler (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input items.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [3:0] task_index, [19:4] exec_time, [35:20] period, [51:36] rel_deadline
	input  logic [ptts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [1:0] action
	input  logic [ptts_pkg::ACT_W-1:0]        s_axis_tuser,
	// Result items.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [3:0] chosen_task, [35:4] tick_time
	output logic [ptts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// [0] idle
	output logic                              m_axis_tuser,
	// Configuration writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [ptts_pkg::NUM_W-1:0]        cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_CLEAR = 3'd2;
	localparam logic [2:0] ST_DECR  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam int IDX_W  = ptts_pkg::IDX_W;
	localparam int CNT_W  = ptts_pkg::CNT_W;
	localparam int WORK_W = ptts_pkg::WORK_W;
	localparam int TIME_W = ptts_pkg::TIME_W;
	localparam int NTASK  = ptts_pkg::MAX_TASKS;

	// Task table.
	logic [WORK_W-1:0] job_q    [NTASK];
	logic [WORK_W-1:0] period_q [NTASK];
	logic [WORK_W-1:0] rel_q    [NTASK];
	logic [WORK_W-1:0] rem_q    [NTASK];
	logic [TIME_W-1:0] next_q   [NTASK];
	logic [TIME_W-1:0] dl_q     [NTASK];

	// Sequencer and scan registers.
	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  n_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] time_q;
	logic              found_q;
	logic [IDX_W-1:0]  sel_q;
	logic [TIME_W-1:0] best_key_q;
	logic [WORK_W-1:0] best_rem_q;

	// Configuration.
	logic                       policy_q;
	logic [ptts_pkg::NUM_W-1:0] num_q;

	// Pending and presented results.
	logic                          res_idle_q;
	logic [ptts_pkg::CHOSEN_W-1:0] res_chosen_q;
	logic [TIME_W-1:0]             res_time_q;
	logic                          out_valid_q;
	logic                          out_idle_q;
	logic [ptts_pkg::CHOSEN_W-1:0] out_chosen_q;
	logic [TIME_W-1:0]             out_time_q;

	logic                  in_acc;
	logic [ptts_pkg::ACT_W-1:0]  in_action;
	logic [3:0]            in_index;
	logic [WORK_W-1:0]     in_exec;
	logic [WORK_W-1:0]     in_period;
	logic [WORK_W-1:0]     in_rel;
	logic                  load_ok;
	logic [IDX_W-1:0]      load_idx;
	logic [IDX_W-1:0]      idx;
	logic [CNT_W-1:0]      n_clamp;
	logic                  out_free;
	ptts_pkg::entry_t      cur;
	ptts_pkg::step_t       step;

	// Input field unpacking.
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign in_action = s_axis_tuser;
	assign in_index  = s_axis_tdata[3:0];
	assign in_exec   = s_axis_tdata[19:4];
	assign in_period = s_axis_tdata[35:20];
	assign in_rel    = s_axis_tdata[51:36];
	assign load_ok   = (32'(in_index) < NTASK);
	assign load_idx  = IDX_W'(in_index);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Entries beyond the table size count as the table size.
	always_comb begin
		if (32'(num_q) > NTASK) begin
			n_clamp = CNT_W'(NTASK);
		end else begin
			n_clamp = CNT_W'(num_q);
		end
	end

	// Entry under the scan or clear counter.
	assign idx          = cnt_q[IDX_W-1:0];
	assign cur.job      = job_q[idx];
	assign cur.period   = period_q[idx];
	assign cur.rel      = rel_q[idx];
	assign cur.rem      = rem_q[idx];
	assign cur.next_rel = next_q[idx];
	assign cur.dl       = dl_q[idx];

	ptts_alu u_alu (
		.policy   (policy_q),
		.now      (now_q),
		.cur      (cur),
		.found    (found_q),
		.best_key (best_key_q),
		.res      (step)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= ptts_pkg::POL_RM;
			num_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ptts_pkg::CFG_POLICY:    policy_q <= cfg_data[0];
				ptts_pkg::CFG_NUM_TASKS: num_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Task parameters, written by load items only.
	always_ff @(posedge clk) begin
		if (in_acc && (in_action == ptts_pkg::ACT_LOAD) && load_ok) begin
			job_q[load_idx]    <= in_exec;
			period_q[load_idx] <= in_period;
			rel_q[load_idx]    <= in_rel;
		end
	end

	// Dynamic task state: release updates in the scan, decrement of the chosen task, clearing in the restart sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NTASK; i++) begin
				rem_q[i]  <= '0;
				next_q[i] <= '0;
				dl_q[i]   <= '0;
			end
		end else begin
			case (state_q)
				ST_SCAN: begin
					rem_q[idx]  <= step.upd.rem;
					next_q[idx] <= step.upd.next_rel;
					dl_q[idx]   <= step.upd.dl;
				end
				ST_CLEAR: begin
					rem_q[idx]  <= '0;
					next_q[idx] <= '0;
					dl_q[idx]   <= TIME_W'(rel_q[idx]);
				end
				ST_DECR: begin
					if (found_q) begin
						rem_q[sel_q] <= best_rem_q - WORK_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			n_q          <= '0;
			now_q        <= '0;
			time_q       <= '0;
			found_q      <= 1'b0;
			sel_q        <= '0;
			best_key_q   <= '0;
			best_rem_q   <= '0;
			res_idle_q   <= 1'b1;
			res_chosen_q <= '0;
			res_time_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q        <= '0;
						found_q      <= 1'b0;
						res_idle_q   <= 1'b1;
						res_chosen_q <= '0;
						res_time_q   <= '0;
						case (in_action)
							ptts_pkg::ACT_TICK: begin
								now_q   <= time_q;
								n_q     <= n_clamp;
								state_q <= (n_clamp == '0) ? ST_DECR : ST_SCAN;
							end
							ptts_pkg::ACT_RESTART: begin
								time_q  <= '0;
								state_q <= ST_CLEAR;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					if (step.take) begin
						found_q    <= 1'b1;
						sel_q      <= idx;
						best_key_q <= step.key;
						best_rem_q <= step.upd.rem;
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == n_q - CNT_W'(1)) begin
						state_q <= ST_DECR;
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NTASK - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DECR: begin
					res_idle_q   <= !found_q;
					res_chosen_q <= found_q ? ptts_pkg::CHOSEN_W'(sel_q) : '0;
					res_time_q   <= now_q;
					if (time_q != {TIME_W{1'b1}}) begin
						time_q <= time_q + TIME_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_idle_q   <= res_idle_q;
			out_chosen_q <= res_chosen_q;
			out_time_q   <= res_time_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_idle_q;
	assign m_axis_tdata  = {{(ptts_pkg::OUT_DATA_W - TIME_W - ptts_pkg::CHOSEN_W){1'b0}},
		out_time_q, out_chosen_q};

endmodule

/* src/ptts_check.sv */
// Port-level checks for the periodic task tick scheduler.
module ptts_check (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [ptts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic                             m_axis_tuser
);

	// One item at a time: the input closes right after it takes an item.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input still ready right after an accepted item");

	// An idle result never names a task.
	a_idle_no_task: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3:0] == 4'd0)
		else $error("idle result carries a task index");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed or dropped");

endmodule

bind periodic_task_tick_scheduler ptts_check u_ptts_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
